// ===== design/tes_pkg.sv =====
package tes_pkg;

  localparam int EVENT_SLOTS  = 16;
  localparam int CANCEL_SLOTS = 16;
  localparam int SLOT_IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CAN_IW  = (CANCEL_SLOTS > 1) ? $clog2(CANCEL_SLOTS) : 1;
  localparam int SCAN_MAX = (EVENT_SLOTS > CANCEL_SLOTS) ? EVENT_SLOTS : CANCEL_SLOTS;
  localparam int SCAN_W  = $clog2(SCAN_MAX + 1);
  localparam int LIVE_W  = $clog2(EVENT_SLOTS + 1);

  localparam int TICK_W = 64;
  localparam int ID_W   = 32;
  localparam int TASK_W = 16;
  localparam int MS_W   = 32;
  localparam int TPS_W  = 20;
  localparam int SWP_W  = 16;
  localparam int AGE_W  = 32;
  localparam int FLAG_W = 2;
  localparam int PROD_W = MS_W + TPS_W;

  localparam int FLAG_PERIODIC = 0;
  localparam int FLAG_SWITCH   = 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TPS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWP = 2'd1;
  localparam logic [TPS_W-1:0] TPS_RESET = 20'd100;
  localparam logic [SWP_W-1:0] SWP_RESET = 16'd20;

  typedef enum logic [1:0] {
    REQ_ADD_ONCE, REQ_ADD_PERIODIC, REQ_REMOVE, REQ_TICK
  } req_t;

  typedef enum logic [1:0] {
    KIND_ADD, KIND_REMOVE, KIND_EXPIRY, KIND_TICK
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK, ST_BAD_ID, ST_TABLE_FULL, ST_CANCEL_FULL
  } status_t;

  typedef struct packed {
    logic               found;
    logic [TICK_W-1:0]  deadline;
    logic [AGE_W-1:0]   age;
    logic [SLOT_IW-1:0] idx;
    logic [ID_W-1:0]    ident;
    logic [TASK_W-1:0]  task_id;
    logic [MS_W-1:0]    period;
    logic [FLAG_W-1:0]  flags;
    logic               free_found;
    logic [SLOT_IW-1:0] free_idx;
  } slot_tok_t;

  typedef struct packed {
    logic               wr;
    logic               rearm;
    logic               clr;
    logic               rank_clr;
    logic               rank_step;
    logic               rank_commit;
    logic [SLOT_IW-1:0] idx;
    logic [TICK_W-1:0]  deadline;
    logic [ID_W-1:0]    ident;
    logic [TASK_W-1:0]  task_id;
    logic [MS_W-1:0]    period;
    logic [FLAG_W-1:0]  flags;
    logic [AGE_W-1:0]   age;
    logic [AGE_W-1:0]   bc_age;
    logic               bc_valid;
  } slot_cmd_t;

  typedef struct packed {
    logic              match;
    logic [CAN_IW-1:0] match_idx;
    logic              free_found;
    logic [CAN_IW-1:0] free_idx;
  } can_tok_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [CAN_IW-1:0] idx;
    logic [ID_W-1:0]   ident;
  } can_cmd_t;

endpackage

// ===== design/tes_slot_cell.sv =====
module tes_slot_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tes_pkg::SLOT_IW-1:0] my_idx,
  input  logic [tes_pkg::TICK_W-1:0]  tick,
  input  tes_pkg::slot_cmd_t          cmd,
  input  tes_pkg::slot_tok_t          tok_in,
  output tes_pkg::slot_tok_t          tok_out,
  output logic                        valid,
  output logic [tes_pkg::AGE_W-1:0]   age
);
  import tes_pkg::*;

  logic               valid_r;
  logic [TICK_W-1:0]  deadline_r;
  logic [ID_W-1:0]    ident_r;
  logic [TASK_W-1:0]  task_r;
  logic [MS_W-1:0]    period_r;
  logic [FLAG_W-1:0]  flags_r;
  logic [AGE_W-1:0]   age_r;
  logic [LIVE_W-1:0]  rank_r;
  slot_tok_t          tok_r;
  slot_tok_t          tok_nxt;
  logic               sel;
  logic               elig;

  assign sel = (cmd.idx == my_idx);

  // Keep the running best unless this slot is due and earlier (or older on a tie).
  always_comb begin
    tok_nxt = tok_in;
    elig = valid_r && (deadline_r <= tick);
    if (elig && (!tok_in.found || deadline_r < tok_in.deadline ||
                 (deadline_r == tok_in.deadline && age_r < tok_in.age))) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.deadline = deadline_r;
      tok_nxt.age      = age_r;
      tok_nxt.idx      = my_idx;
      tok_nxt.ident    = ident_r;
      tok_nxt.task_id  = task_r;
      tok_nxt.period   = period_r;
      tok_nxt.flags    = flags_r;
    end
    if (!tok_in.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.wr && sel) begin
      valid_r <= 1'b1;
    end else if (cmd.clr && sel) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (cmd.wr && sel) begin
      deadline_r <= cmd.deadline;
      ident_r    <= cmd.ident;
      task_r     <= cmd.task_id;
      period_r   <= cmd.period;
      flags_r    <= cmd.flags;
      age_r      <= cmd.age;
    end else if (cmd.rearm && sel) begin
      deadline_r <= cmd.deadline;
      age_r      <= cmd.age;
    end else if (cmd.rank_commit && valid_r) begin
      age_r <= AGE_W'(rank_r);
    end
    if (cmd.rank_clr) begin
      rank_r <= '0;
    end else if (cmd.rank_step && cmd.bc_valid && cmd.bc_age < age_r) begin
      rank_r <= rank_r + LIVE_W'(1);
    end
  end

  assign tok_out = tok_r;
  assign valid   = valid_r;
  assign age     = age_r;

endmodule

// ===== design/tes_cancel_cell.sv =====
module tes_cancel_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tes_pkg::CAN_IW-1:0] my_idx,
  input  logic [tes_pkg::ID_W-1:0]   key,
  input  tes_pkg::can_cmd_t          cmd,
  input  tes_pkg::can_tok_t          tok_in,
  output tes_pkg::can_tok_t          tok_out
);
  import tes_pkg::*;

  logic            valid_r;
  logic [ID_W-1:0] ident_r;
  can_tok_t        tok_r;
  can_tok_t        tok_nxt;
  logic            sel;

  assign sel = (cmd.idx == my_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.match && valid_r && ident_r == key) begin
      tok_nxt.match     = 1'b1;
      tok_nxt.match_idx = my_idx;
    end
    if (!tok_in.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.set && sel) begin
      valid_r <= 1'b1;
    end else if (cmd.clr && sel) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (cmd.set && sel) begin
      ident_r <= cmd.ident;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== design/tes_ms2tick.sv =====
module tes_ms2tick (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tes_pkg::MS_W-1:0]   ms,
  input  logic [tes_pkg::TPS_W-1:0]  tps,
  output logic                       busy,
  output logic [tes_pkg::PROD_W-1:0] ticks
);
  import tes_pkg::*;

  localparam int MS_PER_S = 1000;
  localparam int REM_W    = $clog2(MS_PER_S);
  localparam int DIG_W    = 16;
  localparam int DIGITS   = (PROD_W + DIG_W - 1) / DIG_W;
  localparam int WORK_W   = DIGITS * DIG_W;
  localparam int CUR_W    = REM_W + DIG_W;
  localparam int RECIP_SH = CUR_W + REM_W;
  localparam int MUL_W    = 2 * CUR_W + 1;
  localparam int CNT_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  // Rounded-up reciprocal of 1000; exact for every partial dividend below 2^CUR_W.
  localparam logic [CUR_W:0] RECIP = (CUR_W+1)'((64'd1 << RECIP_SH) / MS_PER_S + 1);

  logic [WORK_W-1:0] work_r;
  logic [REM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [CUR_W-1:0]  cur;
  logic [MUL_W-1:0]  prod;
  logic [DIG_W-1:0]  q_dig;
  logic [CUR_W-1:0]  back;
  logic [REM_W-1:0]  rem_nxt;

  // Long division by 1000 one 16-bit digit a cycle. Each quotient digit comes
  // from a reciprocal multiply of the running remainder joined with the next
  // dividend digit. The dividend shifts out at the top while quotient digits
  // enter at the bottom.
  assign cur     = {rem_r, work_r[WORK_W-1 -: DIG_W]};
  assign prod    = {{(CUR_W+1){1'b0}}, cur} * {{CUR_W{1'b0}}, RECIP};
  assign q_dig   = prod[RECIP_SH +: DIG_W];
  assign back    = CUR_W'(q_dig) * CUR_W'(MS_PER_S);
  assign rem_nxt = REM_W'(cur - back);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CNT_W'(DIGITS - 1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= WORK_W'(PROD_W'(ms) * PROD_W'(tps));
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      work_r <= {work_r[WORK_W-DIG_W-1:0], q_dig};
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  assign busy  = busy_r;
  assign ticks = work_r[PROD_W-1:0];

endmodule

// ===== design/timer_event_scheduler_top.sv =====
// Channel   Direction  Handshake              Contents
// in_*      input      in_tvalid/in_tready    request kind in tuser, request fields in tdata
// out_*     output     out_tvalid/out_tready  result kind in tuser, end of results in tlast
// cfg_*     input      cfg_we (no handshake)  register index and value
//
// One request is handled at a time. An add or a remove is paced by one sweep of the slot
// or cancel cell row (one cell per cycle). A tick takes one slot sweep plus, for every
// event that fires, one slot sweep, one cancel sweep and, when it re-arms, a conversion
// of the period to ticks and a deadline write. When the event age counter is about to
// wrap, an extra renumbering pass (S_RANK_CLR, S_RANK over every slot, S_RANK_DONE) runs.
// Reset is synchronous and clears all valid bits at once.
// A stalled output holds the result register and the sequencer waits on it.
module timer_event_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // delay_ms[31:0], owner_task[47:32], is_switch[48], event_id[80:49], zero fill
  input  logic [87:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_id[31:0], notify_task[47:32], status[49:48], switch_needed[50], zero fill
  output logic [55:0] out_tdata,
  // result_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic                             cfg_we,
  input  logic [tes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tes_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tes_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_EMIT, S_ADD_SCAN, S_ADD_CONV, S_ADD_WR, S_REM_SCAN,
    S_TICK_SCAN, S_TICK_CAN, S_TICK_ACT, S_TICK_POST, S_REARM_CONV, S_REARM_WR,
    S_RANK_CLR, S_RANK, S_RANK_DONE
  } state_t;

  state_t state_r, emit_ret_r, rank_ret_r;

  logic [TPS_W-1:0]   tps_r;
  logic [SWP_W-1:0]   swp_r;
  logic [TICK_W-1:0]  tick_r;
  logic [ID_W-1:0]    next_id_r;
  logic [AGE_W-1:0]   age_next_r;
  logic [SCAN_W-1:0]  cnt_r;
  logic [SLOT_IW-1:0] rank_j_r;
  logic [LIVE_W-1:0]  live_r;
  logic               need_sw_r;

  logic [1:0]         req_type_r;
  logic [MS_W-1:0]    req_ms_r;
  logic [TASK_W-1:0]  req_task_r;
  logic               req_sw_r;
  logic [ID_W-1:0]    req_id_r;
  logic [ID_W-1:0]    key_r;
  logic [SLOT_IW-1:0] slot_idx_r;
  logic [ID_W-1:0]    best_ident_r;
  logic [TASK_W-1:0]  best_task_r;
  logic [MS_W-1:0]    best_period_r;
  logic [FLAG_W-1:0]  best_flags_r;
  logic               can_match_r;
  logic [CAN_IW-1:0]  can_idx_r;

  logic [1:0]         res_kind_r;
  logic [ID_W-1:0]    res_id_r;
  logic [TASK_W-1:0]  res_task_r;
  logic [1:0]         res_status_r;
  logic               res_sw_r;
  logic               res_last_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [ID_W-1:0]    out_id_r;
  logic [TASK_W-1:0]  out_task_r;
  logic [1:0]         out_status_r;
  logic               out_sw_r;
  logic               out_last_r;

  logic [1:0]         in_type;
  logic [MS_W-1:0]    in_ms;
  logic [TASK_W-1:0]  in_task;
  logic               in_sw;
  logic [ID_W-1:0]    in_id;
  logic               in_fire;
  logic               out_free;

  slot_tok_t          stok [EVENT_SLOTS+1];
  can_tok_t           ctok [CANCEL_SLOTS+1];
  logic               cell_valid [EVENT_SLOTS];
  logic [AGE_W-1:0]   cell_age [EVENT_SLOTS];
  slot_cmd_t          scmd;
  can_cmd_t           ccmd;

  logic               conv_start;
  logic [MS_W-1:0]    conv_ms;
  logic               conv_busy;
  logic [PROD_W-1:0]  conv_ticks;
  logic [TICK_W-1:0]  rearm_ticks;
  logic               ev_scan_done;
  logic               can_scan_done;
  logic               age_wrap;
  logic               use_new_id;
  logic [ID_W-1:0]    new_id_inc;

  assign in_type = in_tuser;
  assign in_ms   = in_tdata[31:0];
  assign in_task = in_tdata[47:32];
  assign in_sw   = in_tdata[48];
  assign in_id   = in_tdata[80:49];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign ev_scan_done  = (cnt_r == SCAN_W'(EVENT_SLOTS));
  assign can_scan_done = (cnt_r == SCAN_W'(CANCEL_SLOTS));
  assign age_wrap      = (age_next_r == '1);
  assign use_new_id    = (req_type_r == REQ_ADD_ONCE) || (req_id_r == '0);
  assign new_id_inc    = (next_id_r + ID_W'(1) == '0) ? ID_W'(1) : next_id_r + ID_W'(1);
  assign rearm_ticks   = (conv_ticks == '0) ? TICK_W'(1) : TICK_W'(conv_ticks);

  // Both cell rows sweep from index 0 with an empty token.
  assign stok[0] = '0;
  assign ctok[0] = '0;

  for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_slot
    tes_slot_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (SLOT_IW'(i)),
      .tick    (tick_r),
      .cmd     (scmd),
      .tok_in  (stok[i]),
      .tok_out (stok[i+1]),
      .valid   (cell_valid[i]),
      .age     (cell_age[i])
    );
  end

  for (genvar i = 0; i < CANCEL_SLOTS; i++) begin : g_cancel
    tes_cancel_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (CAN_IW'(i)),
      .key     (key_r),
      .cmd     (ccmd),
      .tok_in  (ctok[i]),
      .tok_out (ctok[i+1])
    );
  end

  // The divider is started on an accepted request (for adds), and when an
  // expired switch or periodic event needs its next deadline.
  always_comb begin
    conv_start = 1'b0;
    conv_ms    = best_period_r;
    if (state_r == S_IDLE) begin
      conv_start = in_fire && (in_type == REQ_ADD_ONCE || in_type == REQ_ADD_PERIODIC);
      conv_ms    = in_ms;
    end else if (state_r == S_TICK_ACT) begin
      conv_start = !can_match_r && best_flags_r[FLAG_SWITCH];
      conv_ms    = MS_W'(swp_r);
    end else if (state_r == S_TICK_POST) begin
      conv_start = best_flags_r[FLAG_PERIODIC];
    end
  end

  tes_ms2tick u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .ms    (conv_ms),
    .tps   (tps_r),
    .busy  (conv_busy),
    .ticks (conv_ticks)
  );

  // Commands to the slot row.
  always_comb begin
    scmd          = '0;
    scmd.idx      = slot_idx_r;
    scmd.ident    = use_new_id ? next_id_r : req_id_r;
    scmd.task_id  = req_task_r;
    scmd.period   = req_ms_r;
    scmd.flags    = {req_sw_r, req_type_r == REQ_ADD_PERIODIC};
    scmd.age      = age_next_r;
    scmd.deadline = tick_r + TICK_W'(conv_ticks);
    scmd.bc_age   = cell_age[rank_j_r];
    scmd.bc_valid = cell_valid[rank_j_r];
    case (state_r)
      S_ADD_WR:    scmd.wr = 1'b1;
      S_REARM_WR: begin
        scmd.rearm    = 1'b1;
        scmd.deadline = tick_r + rearm_ticks;
      end
      S_TICK_ACT:  scmd.clr = can_match_r;
      S_TICK_POST: scmd.clr = !best_flags_r[FLAG_PERIODIC];
      S_RANK_CLR:  scmd.rank_clr = 1'b1;
      S_RANK:      scmd.rank_step = 1'b1;
      S_RANK_DONE: scmd.rank_commit = 1'b1;
      default:     scmd.wr = 1'b0;
    endcase
  end

  // Commands to the cancel row: record on a remove, drop one record on expiry.
  always_comb begin
    ccmd       = '0;
    ccmd.ident = key_r;
    ccmd.idx   = ctok[CANCEL_SLOTS].free_idx;
    if (state_r == S_REM_SCAN && can_scan_done) begin
      ccmd.set = !ctok[CANCEL_SLOTS].match && ctok[CANCEL_SLOTS].free_found;
    end else if (state_r == S_TICK_ACT) begin
      ccmd.clr = can_match_r;
      ccmd.idx = can_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      swp_r <= SWP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TPS) begin
        tps_r <= cfg_wdata;
      end else if (cfg_index == CFG_SWP) begin
        swp_r <= cfg_wdata[SWP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_ret_r  <= S_IDLE;
      rank_ret_r  <= S_ADD_WR;
      tick_r      <= '0;
      next_id_r   <= ID_W'(1);
      age_next_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register empties on a transfer unless a new result is loaded.
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_type_r   <= in_type;
            req_ms_r     <= in_ms;
            req_task_r   <= in_task;
            req_sw_r     <= in_sw;
            req_id_r     <= in_id;
            key_r        <= in_id;
            cnt_r        <= '0;
            need_sw_r    <= 1'b0;
            res_task_r   <= '0;
            res_sw_r     <= 1'b0;
            res_last_r   <= 1'b1;
            emit_ret_r   <= S_IDLE;
            if (in_type == REQ_TICK) begin
              res_status_r <= ST_OK;
              tick_r       <= tick_r + TICK_W'(1);
              state_r      <= S_TICK_SCAN;
            end else if (in_type == REQ_REMOVE) begin
              res_kind_r <= KIND_REMOVE;
              res_id_r   <= in_id;
              if (in_id == '0 || in_id > next_id_r) begin
                res_status_r <= ST_BAD_ID;
                state_r      <= S_EMIT;
              end else begin
                res_status_r <= ST_OK;
                state_r      <= S_REM_SCAN;
              end
            end else begin
              res_kind_r <= KIND_ADD;
              res_id_r   <= '0;
              if (in_type == REQ_ADD_PERIODIC && in_id != '0 && in_id > next_id_r) begin
                res_status_r <= ST_BAD_ID;
                state_r      <= S_EMIT;
              end else begin
                res_status_r <= ST_OK;
                state_r      <= S_ADD_SCAN;
              end
            end
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= res_kind_r;
            out_id_r     <= res_id_r;
            out_task_r   <= res_task_r;
            out_status_r <= res_status_r;
            out_sw_r     <= res_sw_r;
            out_last_r   <= res_last_r;
            state_r      <= emit_ret_r;
          end
        end

        S_ADD_SCAN: begin
          if (ev_scan_done) begin
            slot_idx_r <= stok[EVENT_SLOTS].free_idx;
            if (!stok[EVENT_SLOTS].free_found) begin
              res_status_r <= ST_TABLE_FULL;
              state_r      <= S_EMIT;
            end else begin
              state_r <= S_ADD_CONV;
            end
          end else begin
            cnt_r <= cnt_r + SCAN_W'(1);
          end
        end

        S_ADD_CONV: begin
          if (!conv_busy) begin
            rank_ret_r <= S_ADD_WR;
            state_r    <= age_wrap ? S_RANK_CLR : S_ADD_WR;
          end
        end

        S_ADD_WR: begin
          age_next_r <= age_next_r + AGE_W'(1);
          res_id_r   <= scmd.ident;
          if (use_new_id) begin
            next_id_r <= new_id_inc;
          end
          state_r <= S_EMIT;
        end

        S_REM_SCAN: begin
          if (can_scan_done) begin
            if (!ctok[CANCEL_SLOTS].match && !ctok[CANCEL_SLOTS].free_found) begin
              res_status_r <= ST_CANCEL_FULL;
            end
            state_r <= S_EMIT;
          end else begin
            cnt_r <= cnt_r + SCAN_W'(1);
          end
        end

        S_TICK_SCAN: begin
          if (ev_scan_done) begin
            cnt_r <= '0;
            if (!stok[EVENT_SLOTS].found) begin
              res_kind_r   <= KIND_TICK;
              res_id_r     <= '0;
              res_task_r   <= '0;
              res_status_r <= ST_OK;
              res_sw_r     <= need_sw_r;
              res_last_r   <= 1'b1;
              emit_ret_r   <= S_IDLE;
              state_r      <= S_EMIT;
            end else begin
              slot_idx_r    <= stok[EVENT_SLOTS].idx;
              best_ident_r  <= stok[EVENT_SLOTS].ident;
              best_task_r   <= stok[EVENT_SLOTS].task_id;
              best_period_r <= stok[EVENT_SLOTS].period;
              best_flags_r  <= stok[EVENT_SLOTS].flags;
              key_r         <= stok[EVENT_SLOTS].ident;
              state_r       <= S_TICK_CAN;
            end
          end else begin
            cnt_r <= cnt_r + SCAN_W'(1);
          end
        end

        S_TICK_CAN: begin
          if (can_scan_done) begin
            can_match_r <= ctok[CANCEL_SLOTS].match;
            can_idx_r   <= ctok[CANCEL_SLOTS].match_idx;
            state_r     <= S_TICK_ACT;
          end else begin
            cnt_r <= cnt_r + SCAN_W'(1);
          end
        end

        S_TICK_ACT: begin
          cnt_r <= '0;
          if (can_match_r) begin
            state_r <= S_TICK_SCAN;
          end else if (best_flags_r[FLAG_SWITCH]) begin
            need_sw_r <= 1'b1;
            state_r   <= S_REARM_CONV;
          end else begin
            res_kind_r   <= KIND_EXPIRY;
            res_id_r     <= best_ident_r;
            res_task_r   <= best_task_r;
            res_status_r <= ST_OK;
            res_sw_r     <= 1'b0;
            res_last_r   <= 1'b0;
            emit_ret_r   <= S_TICK_POST;
            state_r      <= S_EMIT;
          end
        end

        S_TICK_POST: begin
          cnt_r   <= '0;
          state_r <= best_flags_r[FLAG_PERIODIC] ? S_REARM_CONV : S_TICK_SCAN;
        end

        S_REARM_CONV: begin
          if (!conv_busy) begin
            rank_ret_r <= S_REARM_WR;
            state_r    <= age_wrap ? S_RANK_CLR : S_REARM_WR;
          end
        end

        S_REARM_WR: begin
          age_next_r <= age_next_r + AGE_W'(1);
          cnt_r      <= '0;
          state_r    <= S_TICK_SCAN;
        end

        S_RANK_CLR: begin
          rank_j_r <= '0;
          live_r   <= '0;
          state_r  <= S_RANK;
        end

        S_RANK: begin
          if (cell_valid[rank_j_r]) begin
            live_r <= live_r + LIVE_W'(1);
          end
          rank_j_r <= rank_j_r + SLOT_IW'(1);
          if (rank_j_r == SLOT_IW'(EVENT_SLOTS - 1)) begin
            state_r <= S_RANK_DONE;
          end
        end

        S_RANK_DONE: begin
          age_next_r <= AGE_W'(live_r);
          state_r    <= rank_ret_r;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_sw_r, out_status_r, out_task_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/tes_checker.sv =====
module tes_checker
  import tes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [87:0]           in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [55:0]           out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    open_count,
  output logic [ID_W-1:0]       next_ident
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t             kind;
    logic [ID_W-1:0]   ident;
    logic [TASK_W-1:0] task_id;
    status_t           status;
    logic              sw;
    logic              last;
  } response_t;

  response_t pending_responses[$];

  // Shadow of the scheduler state.
  logic [TPS_W-1:0]  tps;
  logic [SWP_W-1:0]  swp;
  logic [TICK_W-1:0] now_tick;
  logic [ID_W-1:0]   id_next;
  logic [AGE_W-1:0]  age_next;
  logic              ev_valid [EVENT_SLOTS];
  logic [TICK_W-1:0] ev_due   [EVENT_SLOTS];
  logic [ID_W-1:0]   ev_ident [EVENT_SLOTS];
  logic [TASK_W-1:0] ev_task  [EVENT_SLOTS];
  logic [MS_W-1:0]   ev_period[EVENT_SLOTS];
  logic [FLAG_W-1:0] ev_flags [EVENT_SLOTS];
  logic [AGE_W-1:0]  ev_age   [EVENT_SLOTS];
  logic              cx_valid [CANCEL_SLOTS];
  logic [ID_W-1:0]   cx_ident [CANCEL_SLOTS];
  int                errors;

  function automatic logic [TICK_W-1:0] ms_to_ticks(logic [MS_W-1:0] ms);
    logic [TICK_W-1:0] prod;
    prod = {32'b0, ms} * {44'b0, tps};
    return prod / 1000;
  endfunction

  // Renumbers live slots by rank right before the age counter would wrap.
  function automatic logic [AGE_W-1:0] take_age();
    logic [AGE_W-1:0] rank[EVENT_SLOTS];
    logic [AGE_W-1:0] live;
    logic [AGE_W-1:0] got;
    if (age_next == '1) begin
      live = 0;
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        rank[i] = 0;
        if (ev_valid[i]) begin
          live++;
          for (int j = 0; j < EVENT_SLOTS; j++)
            if (ev_valid[j] && ev_age[j] < ev_age[i]) rank[i]++;
        end
      end
      for (int i = 0; i < EVENT_SLOTS; i++)
        if (ev_valid[i]) ev_age[i] = rank[i];
      age_next = live;
    end
    got = age_next;
    age_next++;
    return got;
  endfunction

  task automatic rearm(int s, logic [MS_W-1:0] ms);
    logic [TICK_W-1:0] d;
    d = ms_to_ticks(ms);
    if (d < 1) d = 1;
    ev_due[s] = now_tick + d;
    ev_age[s] = take_age();
  endtask

  function automatic logic drop_cancel(logic [ID_W-1:0] id);
    for (int c = 0; c < CANCEL_SLOTS; c++)
      if (cx_valid[c] && cx_ident[c] == id) begin
        cx_valid[c] = 1'b0;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  task automatic push(kind_t k, logic [ID_W-1:0] id, logic [TASK_W-1:0] t, status_t st,
                      logic sw, logic last);
    response_t r;
    r.kind = k; r.ident = id; r.task_id = t; r.status = st; r.sw = sw; r.last = last;
    pending_responses.push_back(r);
  endtask

  task automatic compute_responses(req_t req, logic [MS_W-1:0] ms, logic [TASK_W-1:0] owner,
                                   logic sw, logic [ID_W-1:0] id);
    int   s;
    int   c;
    int   best;
    logic hit;
    logic switch_fired;
    case (req)
      REQ_ADD_ONCE, REQ_ADD_PERIODIC: begin
        if (req == REQ_ADD_PERIODIC && id != 0 && id > id_next) begin
          push(KIND_ADD, '0, '0, ST_BAD_ID, 1'b0, 1'b1);
          return;
        end
        s = -1;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--)
          if (!ev_valid[i]) s = i;
        if (s < 0) begin
          push(KIND_ADD, '0, '0, ST_TABLE_FULL, 1'b0, 1'b1);
          return;
        end
        if (req == REQ_ADD_ONCE || id == 0) begin
          id = id_next;
          id_next++;
          if (id_next == 0) id_next = 1;
        end
        ev_due[s]    = now_tick + ms_to_ticks(ms);
        ev_ident[s]  = id;
        ev_task[s]   = owner;
        ev_period[s] = ms;
        ev_flags[s]  = '0;
        ev_flags[s][FLAG_PERIODIC] = (req == REQ_ADD_PERIODIC);
        ev_flags[s][FLAG_SWITCH]   = sw;
        ev_age[s]    = take_age();
        ev_valid[s]  = 1'b1;
        push(KIND_ADD, id, '0, ST_OK, 1'b0, 1'b1);
      end
      REQ_REMOVE: begin
        if (id == 0 || id > id_next) begin
          push(KIND_REMOVE, id, '0, ST_BAD_ID, 1'b0, 1'b1);
          return;
        end
        hit = 1'b0;
        c = -1;
        for (int i = CANCEL_SLOTS - 1; i >= 0; i--) begin
          if (cx_valid[i] && cx_ident[i] == id) hit = 1'b1;
          if (!cx_valid[i]) c = i;
        end
        if (hit) begin
          push(KIND_REMOVE, id, '0, ST_OK, 1'b0, 1'b1);
        end else if (c < 0) begin
          push(KIND_REMOVE, id, '0, ST_CANCEL_FULL, 1'b0, 1'b1);
        end else begin
          cx_valid[c] = 1'b1;
          cx_ident[c] = id;
          push(KIND_REMOVE, id, '0, ST_OK, 1'b0, 1'b1);
        end
      end
      default: begin
        switch_fired = 1'b0;
        now_tick++;
        for (int it = 0; it < EVENT_SLOTS; it++) begin
          best = -1;
          for (int i = 0; i < EVENT_SLOTS; i++) begin
            if (!ev_valid[i] || ev_due[i] > now_tick) continue;
            if (best < 0 || ev_due[i] < ev_due[best] ||
                (ev_due[i] == ev_due[best] && ev_age[i] < ev_age[best]))
              best = i;
          end
          if (best < 0) break;
          if (drop_cancel(ev_ident[best])) begin
            ev_valid[best] = 1'b0;
            continue;
          end
          if (ev_flags[best][FLAG_SWITCH]) begin
            switch_fired = 1'b1;
            rearm(best, {16'b0, swp});
            continue;
          end
          push(KIND_EXPIRY, ev_ident[best], ev_task[best], ST_OK, 1'b0, 1'b0);
          if (ev_flags[best][FLAG_PERIODIC]) rearm(best, ev_period[best]);
          else ev_valid[best] = 1'b0;
        end
        push(KIND_TICK, '0, '0, ST_OK, switch_fired, 1'b1);
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: mismatch in %s, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      tps = TPS_RESET;
      swp = SWP_RESET;
      now_tick = '0;
      id_next = 1;
      age_next = '0;
      errors = 0;
      pending_responses.delete();
      for (int i = 0; i < EVENT_SLOTS; i++) ev_valid[i] = 1'b0;
      for (int i = 0; i < CANCEL_SLOTS; i++) cx_valid[i] = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TPS: tps = cfg_wdata;
          CFG_SWP: swp = cfg_wdata[SWP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        compute_responses(req_t'(in_tuser), in_tdata[31:0], in_tdata[47:32], in_tdata[48],
                          in_tdata[80:49]);
      if (out_tvalid && out_tready) begin
        if (pending_responses.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %h id %h", $time,
                   out_tuser, out_tdata[31:0]);
        end else begin
          want = pending_responses.pop_front();
          compare_field("result_kind", want.kind, out_tuser);
          compare_field("result_id", want.ident, out_tdata[31:0]);
          compare_field("notify_task", want.task_id, out_tdata[47:32]);
          compare_field("status", want.status, out_tdata[49:48]);
          compare_field("switch_needed", want.sw, out_tdata[50]);
          compare_field("last", want.last, out_tlast);
        end
      end
    end
    fail_count <= errors;
    open_count <= pending_responses.size();
    next_ident <= id_next;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import tes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_PER_PHASE = 56;
  // An index beyond the two registers; the block must ignore the write.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [87:0]           in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [55:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int              fail_count;
  int              open_count;
  logic [ID_W-1:0] next_ident;
  int              send_idle_pct;
  int              stall_pct;
  int              quiet_cycles;
  int              huge_left;
  logic [TPS_W-1:0] tps_now;

  timer_event_scheduler_top dut (.*);

  tes_checker checker_i (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver drops ready at random, per cycle, at the current stall rate.
  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one request, idling beforehand at the sender's rate, and returns
  // at the edge where the transfer happens. Valid stays high afterwards so
  // back-to-back requests need no idle gap.
  task automatic send_req(req_t req, logic [31:0] ms, logic [15:0] owner, logic sw,
                          logic [31:0] id);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'b0, id, sw, owner, ms};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending and waits until every predicted result has been seen, then
  // lets the block settle before any register write.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_TPS) tps_now = val;
  endtask

  // Mostly delays of a few ticks at the current rate, so events actually fire;
  // a couple of full-range delays cover the upper bits and hold a slot forever.
  function automatic logic [31:0] pick_delay();
    if (huge_left > 0 && $urandom_range(0, 39) == 0) begin
      huge_left--;
      return $urandom | 32'h8000_0000;
    end
    return $urandom_range(0, 8000 / tps_now);
  endfunction

  function automatic logic [31:0] pick_known_id();
    logic [31:0] lo;
    lo = (next_ident > 20) ? next_ident - 20 : 1;
    return $urandom_range(lo, next_ident);
  endfunction

  task automatic random_request();
    int          r;
    int          sel;
    logic [31:0] id;
    r   = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (r < 30) begin
      send_req(REQ_TICK, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 55) begin
      send_req(REQ_ADD_ONCE, pick_delay(), $urandom, ($urandom_range(0, 19) == 0), $urandom);
    end else if (r < 75) begin
      if (sel < 65) id = 0;
      else if (sel < 88) id = pick_known_id();
      else if (sel < 94) id = next_ident + $urandom_range(1, 1000);
      else id = $urandom;
      send_req(REQ_ADD_PERIODIC, pick_delay(), $urandom, ($urandom_range(0, 19) == 0), id);
    end else begin
      if (sel < 70) id = pick_known_id();
      else if (sel < 80) id = 0;
      else if (sel < 90) id = next_ident + 1;
      else id = $urandom;
      send_req(REQ_REMOVE, $urandom, $urandom, $urandom, id);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = REQ_TICK;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TPS;
    cfg_wdata     = '0;
    send_idle_pct = 17;
    stall_pct     = 48;
    quiet_cycles  = 0;
    huge_left     = 2;
    tps_now       = TPS_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: default rates, sender idles lightly and the receiver heavily.
    write_reg(CFG_TPS, 20'd100);
    write_reg(CFG_SWP, 20'd20);
    write_reg(CFG_UNUSED, 20'hFFFFF);

    // Ids 1..3: a zero-delay one-shot, a one-tick periodic and a switch event.
    send_req(REQ_ADD_ONCE, 32'd0, 16'hFFFF, 1'b0, 32'd0);
    send_req(REQ_ADD_PERIODIC, 32'd10, 16'h0000, 1'b0, 32'd0);
    send_req(REQ_ADD_PERIODIC, 32'd0, 16'h1234, 1'b1, 32'd0);
    // Invalid ids: zero, beyond the next id, and a periodic reuse beyond it.
    send_req(REQ_REMOVE, 32'd0, 16'd0, 1'b0, 32'd0);
    send_req(REQ_REMOVE, 32'd0, 16'd0, 1'b0, 32'd100);
    send_req(REQ_ADD_PERIODIC, 32'd5, 16'd7, 1'b0, 32'd200);
    send_req(REQ_REMOVE, 32'd0, 16'd0, 1'b0, 32'hFFFF_FFFF);
    send_req(REQ_TICK, 32'd0, 16'd0, 1'b0, 32'd0);
    // Cancel both re-arming events; the second remove of the same id is a no-op.
    send_req(REQ_REMOVE, 32'd0, 16'd0, 1'b0, 32'd2);
    send_req(REQ_REMOVE, 32'd0, 16'd0, 1'b0, 32'd2);
    send_req(REQ_REMOVE, 32'd0, 16'd0, 1'b0, 32'd3);
    repeat (3) send_req(REQ_TICK, 32'd0, 16'd0, 1'b0, 32'd0);
    // Maximum delay: this event never expires during the run.
    send_req(REQ_ADD_ONCE, 32'hFFFF_FFFF, 16'hA5A5, 1'b0, 32'hFFFF_FFFF);
    // Reuse of a dropped id with zero period, so the re-arm is raised to one tick.
    send_req(REQ_ADD_PERIODIC, 32'd0, 16'd1, 1'b0, 32'd2);
    // A one-shot add with the switch flag still re-arms.
    send_req(REQ_ADD_ONCE, 32'd0, 16'd2, 1'b1, 32'd0);
    // Fill the table; the last add finds no free slot.
    for (int i = 0; i < 14; i++) send_req(REQ_ADD_ONCE, 32'd10, i, 1'b0, 32'd0);
    send_req(REQ_TICK, 32'd0, 16'd0, 1'b0, 32'd0);
    send_req(REQ_TICK, 32'd0, 16'd0, 1'b0, 32'd0);

    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      // Once, hold off until the block has delivered everything.
      if (i == RANDOM_PER_PHASE / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
      end
      random_request();
    end
    drain();

    // Phase two: slowest tick rate and longest switch period, rates swapped.
    write_reg(CFG_TPS, 20'd1);
    write_reg(CFG_SWP, 20'd65535);
    send_idle_pct = 48;
    stall_pct     = 17;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) random_request();
    drain();

    // Phase three: fastest tick rate and shortest switch period, no idling.
    write_reg(CFG_TPS, 20'd1000000);
    write_reg(CFG_SWP, 20'd1);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) random_request();
    // Twenty distinct valid ids overrun the cancel store.
    for (int i = 0; i < 20; i++)
      send_req(REQ_REMOVE, 32'd0, 16'd0, 1'b0, next_ident - i);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
